@@ design/sfla_pkg.sv @@
// ============================================================================
// sfla_pkg
// Shared types, constants and helpers for the segment free-list allocator.
// ============================================================================
package sfla_pkg;

   localparam int FREE_ENTRIES = 64;
   localparam int SEG_ENTRIES  = 64;
   localparam int ADDR_BITS    = 16;

   localparam int MAX_ENTRIES = (FREE_ENTRIES > SEG_ENTRIES) ? FREE_ENTRIES : SEG_ENTRIES;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int FIDX_W      = $clog2(FREE_ENTRIES);
   localparam int SIDX_W      = (SEG_ENTRIES > 1) ? $clog2(SEG_ENTRIES) : 1;
   localparam int FCNT_W      = $clog2(FREE_ENTRIES + 1);
   localparam int SCNT_W      = $clog2(SEG_ENTRIES + 1);
   localparam int CMP_W       = 33;

   localparam int SIZE_W      = 16;
   localparam int OWNER_W     = 16;
   localparam int ADDR_OUT_W  = 16;
   localparam int STATUS_W    = 3;
   localparam int FREED_W     = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [SIZE_W-1:0]    DEFAULT_MEMORY_SIZE = 16'd1000;
   localparam logic [FREED_W-1:0]   FREED_MAX           = '1;
   localparam logic [ADDR_BITS-1:0] ADDR_MASK           = '1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_NO_FIT    = 3'd1,
      ST_SEG_FULL  = 3'd2,
      ST_UNKNOWN   = 3'd3,
      ST_FREE_FULL = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MEMORY_SIZE    = 2'd0,
      CSR_PLACEMENT_MODE = 2'd1
   } csr_index_type;

   typedef enum logic {
      KIND_CREATE  = 1'b0,
      KIND_DESTROY = 1'b1
   } kind_type;

   typedef enum logic {
      MODE_FIRST_FIT = 1'b0,
      MODE_WORST_FIT = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_APPLY,
      S_GATHER,
      S_FILL,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                 valid;
      logic [ADDR_BITS-1:0] start;
      logic [ADDR_BITS-1:0] length;
   } free_entry_type;

   typedef struct packed {
      logic                 valid;
      logic [OWNER_W-1:0]   owner;
      logic [ADDR_BITS-1:0] start;
      logic [SIZE_W-1:0]    length;
   } seg_entry_type;

   typedef struct packed {
      logic                 shift;
      logic                 clear;
      logic                 init_en;
      logic [ADDR_BITS-1:0] init_len;
   } free_ctl_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } seg_ctl_type;

   function automatic logic [ADDR_BITS-1:0] clip_size(input logic [SIZE_W-1:0] size);
      logic [ADDR_BITS-1:0] res;
      if (CMP_W'(size) > CMP_W'(ADDR_MASK)) begin
         res = ADDR_MASK;
      end else begin
         res = ADDR_BITS'(size);
      end
      return res;
   endfunction

endpackage

@@ design/sfla_free_cell.sv @@
// ============================================================================
// sfla_free_cell
// One free-block table entry; loads its neighbor's entry on each shift.
// ============================================================================
module sfla_free_cell
   import sfla_pkg::*;
(
   input  logic           clock,
   input  free_ctl_type   ctl,
   input  free_entry_type entry_in,
   output free_entry_type entry_out
);

   free_entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         entry_ff.valid  <= ctl.init_en;
         entry_ff.start  <= '0;
         entry_ff.length <= ctl.init_len;
      end else if (ctl.shift) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;

endmodule

@@ design/sfla_seg_cell.sv @@
// ============================================================================
// sfla_seg_cell
// One segment table entry; loads its neighbor's entry on each shift.
// ============================================================================
module sfla_seg_cell
   import sfla_pkg::*;
(
   input  logic          clock,
   input  seg_ctl_type   ctl,
   input  seg_entry_type entry_in,
   output seg_entry_type entry_out
);

   logic          valid_ff;
   seg_entry_type data_ff;

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         valid_ff <= 1'b0;
      end else if (ctl.shift) begin
         valid_ff <= entry_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         data_ff <= entry_in;
      end
   end

   always_comb begin
      entry_out       = data_ff;
      entry_out.valid = valid_ff;
   end

endmodule

@@ design/sfla_ctrl.sv @@
// ============================================================================
// sfla_ctrl
// Sequencer at the head of both rotating tables: scan, update, release queue.
// ============================================================================
module sfla_ctrl
   import sfla_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [OWNER_W-1:0]    req_owner,
   input  logic [SIZE_W-1:0]     req_request_size,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [ADDR_OUT_W-1:0] rsp_address,
   output logic [FREED_W-1:0]    rsp_freed_count,
   input  logic                  mode,
   input  free_entry_type        free_head,
   input  seg_entry_type         seg_head,
   output logic                  free_shift,
   output free_entry_type        free_wb,
   output logic                  seg_shift,
   output seg_entry_type         seg_wb
);

   state_type state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic kind_ff;
   logic [OWNER_W-1:0] owner_ff;
   logic [SIZE_W-1:0] reqsz_ff;
   logic found_ff, found_in;
   logic [FIDX_W-1:0] pick_ff, pick_in;
   logic [ADDR_BITS-1:0] best_start_ff, best_start_in;
   logic [ADDR_BITS-1:0] best_len_ff, best_len_in;
   logic slot_found_ff, slot_found_in;
   logic [SIDX_W-1:0] slot_ff, slot_in;
   logic [SCNT_W-1:0] total_ff, total_in;
   logic [SCNT_W-1:0] nonzero_ff, nonzero_in;
   logic [FCNT_W-1:0] empty_ff, empty_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [ADDR_OUT_W-1:0] res_addr_ff, res_addr_in;
   logic [FREED_W-1:0] res_freed_ff, res_freed_in;
   logic rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_OUT_W-1:0] rsp_address_ff;
   logic [FREED_W-1:0] rsp_freed_ff;

   logic [ADDR_BITS-1:0] q_start_ff [SEG_ENTRIES];
   logic [SIZE_W-1:0]    q_len_ff   [SEG_ENTRIES];
   logic [SCNT_W-1:0]    q_cnt_ff, q_cnt_in;
   logic                 q_push, q_pop;

   logic free_act, seg_act, pass_last, fit, better, match, load_rsp;
   logic [ADDR_BITS-1:0] new_len;
   logic [ADDR_BITS-1:0] new_start;

   assign free_act  = ({1'b0, idx_ff} < (IDX_W+1)'(FREE_ENTRIES));
   assign seg_act   = ({1'b0, idx_ff} < (IDX_W+1)'(SEG_ENTRIES));
   assign pass_last = (idx_ff == IDX_W'(MAX_ENTRIES - 1));
   assign fit       = free_head.valid && (CMP_W'(free_head.length) >= CMP_W'(reqsz_ff));
   assign match     = seg_head.valid && (seg_head.owner == owner_ff);
   assign new_len   = ADDR_BITS'(CMP_W'(free_head.length) - CMP_W'(reqsz_ff));
   assign new_start = ADDR_BITS'(CMP_W'(free_head.start) + CMP_W'(reqsz_ff));
   assign load_rsp  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (!found_ff) begin
         better = 1'b1;
      end else if (mode == MODE_FIRST_FIT) begin
         better = free_head.start < best_start_ff;
      end else begin
         better = (free_head.length > best_len_ff) ||
                  ((free_head.length == best_len_ff) && (free_head.start < best_start_ff));
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      best_start_in = best_start_ff;
      best_len_in   = best_len_ff;
      slot_found_in = slot_found_ff;
      slot_in       = slot_ff;
      total_in      = total_ff;
      nonzero_in    = nonzero_ff;
      empty_in      = empty_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_freed_in  = res_freed_ff;
      q_cnt_in      = q_cnt_ff;
      q_push        = 1'b0;
      q_pop         = 1'b0;
      free_shift    = 1'b0;
      seg_shift     = 1'b0;
      free_wb       = free_head;
      seg_wb        = seg_head;
      req_ready     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in      = S_SCAN;
               idx_in        = '0;
               found_in      = 1'b0;
               slot_found_in = 1'b0;
               total_in      = '0;
               nonzero_in    = '0;
               empty_in      = '0;
               res_status_in = ST_OK;
               res_addr_in   = '0;
               res_freed_in  = '0;
            end
         end
         S_SCAN: begin
            free_shift = free_act;
            seg_shift  = seg_act;
            idx_in     = idx_ff + 1'b1;
            if (free_act) begin
               if (fit && better) begin
                  found_in      = 1'b1;
                  pick_in       = FIDX_W'(idx_ff);
                  best_start_in = free_head.start;
                  best_len_in   = free_head.length;
               end
               if (!free_head.valid) begin
                  empty_in = empty_ff + 1'b1;
               end
            end
            if (seg_act) begin
               if (!seg_head.valid && !slot_found_ff) begin
                  slot_found_in = 1'b1;
                  slot_in       = SIDX_W'(idx_ff);
               end
               if (match) begin
                  total_in = total_ff + 1'b1;
                  if (seg_head.length != '0) begin
                     nonzero_in = nonzero_ff + 1'b1;
                  end
               end
            end
            if (pass_last) begin
               idx_in = '0;
               if (kind_ff == KIND_CREATE) begin
                  if (!found_in) begin
                     res_status_in = ST_NO_FIT;
                     state_in      = S_DONE;
                  end else if (!slot_found_in) begin
                     res_status_in = ST_SEG_FULL;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_APPLY;
                  end
               end else begin
                  if (total_in == '0) begin
                     res_status_in = ST_UNKNOWN;
                     state_in      = S_DONE;
                  end else if (CMP_W'(nonzero_in) > CMP_W'(empty_in)) begin
                     res_status_in = ST_FREE_FULL;
                     state_in      = S_DONE;
                  end else begin
                     res_freed_in = (CMP_W'(total_in) > CMP_W'(FREED_MAX)) ?
                                    FREED_MAX : FREED_W'(total_in);
                     state_in     = S_GATHER;
                  end
               end
            end
         end
         S_APPLY: begin
            free_shift = free_act;
            seg_shift  = seg_act;
            idx_in     = idx_ff + 1'b1;
            if (free_act && (idx_ff == IDX_W'(pick_ff))) begin
               free_wb.valid  = (new_len != '0);
               free_wb.length = new_len;
               free_wb.start  = (new_len != '0) ? new_start : '0;
            end
            if (seg_act && (idx_ff == IDX_W'(slot_ff))) begin
               seg_wb.valid  = 1'b1;
               seg_wb.owner  = owner_ff;
               seg_wb.start  = best_start_ff;
               seg_wb.length = reqsz_ff;
            end
            if (pass_last) begin
               idx_in        = '0;
               res_addr_in   = ADDR_OUT_W'(best_start_ff);
               state_in      = S_DONE;
            end
         end
         S_GATHER: begin
            seg_shift = seg_act;
            idx_in    = idx_ff + 1'b1;
            if (seg_act && match) begin
               seg_wb.valid = 1'b0;
               if (seg_head.length != '0) begin
                  q_push   = 1'b1;
                  q_cnt_in = q_cnt_ff + 1'b1;
               end
            end
            if (pass_last) begin
               idx_in   = '0;
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            free_shift = free_act;
            idx_in     = idx_ff + 1'b1;
            if (free_act && !free_head.valid && (q_cnt_ff != '0)) begin
               q_pop          = 1'b1;
               q_cnt_in       = q_cnt_ff - 1'b1;
               free_wb.valid  = 1'b1;
               free_wb.start  = q_start_ff[0];
               free_wb.length = ADDR_BITS'(q_len_ff[0]);
            end
            if (pass_last) begin
               idx_in   = '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         q_cnt_ff     <= '0;
      end else begin
         state_ff <= state_in;
         q_cnt_ff <= q_cnt_in;
         if (state_ff == S_DONE && load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      pick_ff       <= pick_in;
      best_start_ff <= best_start_in;
      best_len_ff   <= best_len_in;
      slot_found_ff <= slot_found_in;
      slot_ff       <= slot_in;
      total_ff      <= total_in;
      nonzero_ff    <= nonzero_in;
      empty_ff      <= empty_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_freed_ff  <= res_freed_in;
      if (state_ff == S_IDLE && req_valid) begin
         kind_ff  <= req_kind;
         owner_ff <= req_owner;
         reqsz_ff <= req_request_size;
      end
      if (state_ff == S_DONE && load_rsp) begin
         rsp_status_ff  <= res_status_ff;
         rsp_address_ff <= res_addr_ff;
         rsp_freed_ff   <= res_freed_ff;
      end
   end

   // release queue: push at fill level, pop shifts toward the head
   always_ff @(posedge clock) begin
      for (int i = 0; i < SEG_ENTRIES; i++) begin
         if (q_push && (q_cnt_ff == SCNT_W'(i))) begin
            q_start_ff[i] <= seg_head.start;
            q_len_ff[i]   <= seg_head.length;
         end else if (q_pop && (i < SEG_ENTRIES - 1)) begin
            q_start_ff[i] <= q_start_ff[(i < SEG_ENTRIES - 1) ? i + 1 : i];
            q_len_ff[i]   <= q_len_ff[(i < SEG_ENTRIES - 1) ? i + 1 : i];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_address     = rsp_address_ff;
   assign rsp_freed_count = rsp_freed_ff;

endmodule

@@ design/segment_free_list_allocator.sv @@
// ============================================================================
// segment_free_list_allocator
// Segment allocator with first-fit / worst-fit placement over a free-block
// table and an owner-tagged segment table, both held as rotating cell rows.
// ============================================================================
//   channel  ports   direction  handshake
//   request  req_*   in         valid / ready
//   response rsp_*   out        valid / ready
//   csr      csr_*   in         write enable, no wait
//
// Each scan or update pass rotates both cell rows once; a gather pass
// rotates only the segment row and a fill pass only the free-block row.
// Create: scan and update passes. Destroy: scan, gather and fill passes.
// Failures end after the scan pass. One transaction in work at a time; the
// response register frees the request side while a result waits. Reset and
// a memory_size write reload the tables.
module segment_free_list_allocator
   import sfla_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [OWNER_W-1:0]    req_owner,
   input  logic [SIZE_W-1:0]     req_request_size,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [ADDR_OUT_W-1:0] rsp_address,
   output logic [FREED_W-1:0]    rsp_freed_count,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic mode_ff;
   logic tbl_clear;
   logic [ADDR_BITS-1:0] init_len;
   logic free_shift, seg_shift;
   free_entry_type free_wb;
   seg_entry_type  seg_wb;
   free_entry_type free_q [FREE_ENTRIES];
   seg_entry_type  seg_q  [SEG_ENTRIES];

   assign tbl_clear = reset || (csr_we && (csr_index == CSR_MEMORY_SIZE));
   assign init_len  = clip_size(reset ? DEFAULT_MEMORY_SIZE : csr_wdata[SIZE_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_FIRST_FIT;
      end else if (csr_we && (csr_index == CSR_PLACEMENT_MODE)) begin
         mode_ff <= csr_wdata[0];
      end
   end

   for (genvar i = 0; i < FREE_ENTRIES; i++) begin : g_free
      free_ctl_type   ctl;
      free_entry_type nxt;
      assign ctl.shift    = free_shift;
      assign ctl.clear    = tbl_clear;
      assign ctl.init_en  = (i == 0) && (init_len != '0);
      assign ctl.init_len = init_len;
      assign nxt = (i == FREE_ENTRIES - 1) ? free_wb :
                   free_q[(i < FREE_ENTRIES - 1) ? i + 1 : i];
      sfla_free_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .entry_in  (nxt),
         .entry_out (free_q[i])
      );
   end

   for (genvar i = 0; i < SEG_ENTRIES; i++) begin : g_seg
      seg_ctl_type   ctl;
      seg_entry_type nxt;
      assign ctl.shift = seg_shift;
      assign ctl.clear = tbl_clear;
      assign nxt = (i == SEG_ENTRIES - 1) ? seg_wb :
                   seg_q[(i < SEG_ENTRIES - 1) ? i + 1 : i];
      sfla_seg_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .entry_in  (nxt),
         .entry_out (seg_q[i])
      );
   end

   sfla_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_owner        (req_owner),
      .req_request_size (req_request_size),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_address      (rsp_address),
      .rsp_freed_count  (rsp_freed_count),
      .mode             (mode_ff),
      .free_head        (free_q[0]),
      .seg_head         (seg_q[0]),
      .free_shift       (free_shift),
      .free_wb          (free_wb),
      .seg_shift        (seg_shift),
      .seg_wb           (seg_wb)
   );

endmodule

@@ design/sfla_checker.sv @@
// ============================================================================
// sfla_checker
// Port-level checks on the allocator's response channel.
// ============================================================================
module sfla_checker
   import sfla_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [STATUS_W-1:0]   rsp_status,
   input logic [ADDR_OUT_W-1:0] rsp_address,
   input logic [FREED_W-1:0]    rsp_freed_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_address == '0) && (rsp_freed_count == '0))
      else $error("failed transaction carries payload");

   a_freed_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_freed_count != '0) |-> (rsp_address == '0))
      else $error("destroy result carries an address");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= ST_FREE_FULL))
      else $error("undefined status code");

endmodule

bind segment_free_list_allocator sfla_checker u_sfla_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_address     (rsp_address),
   .rsp_freed_count (rsp_freed_count)
);
